>>> design/lin_master_frame_engine_assert.svh
// ----------------------------------------------------------------------------
// LIN master frame engine assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef LIN_MASTER_FRAME_ENGINE_ASSERT_SVH
`define LIN_MASTER_FRAME_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Plain property, checked at every edge outside reset
`define LMFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define LMFE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication
`define LMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define LMFE_ASSERT(lbl, clk, rst, prop, msg)
`define LMFE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/lmfe_pkg.sv
// ----------------------------------------------------------------------------
// LIN master frame engine package
// Beat types, codes and the protected-id / checksum helpers.
// ----------------------------------------------------------------------------
package lmfe_pkg;

  // Command opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TX    = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_BREAK   = 3'd0;
  localparam logic [2:0] KIND_TX      = 3'd1;
  localparam logic [2:0] KIND_RX      = 3'd2;
  localparam logic [2:0] KIND_CHECK   = 3'd3;
  localparam logic [2:0] KIND_SEQ_ERR = 3'd4;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_TX     = 4'b0100,
    PH_RX     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] frame_id;
    logic       classic_sum;
    logic [7:0] data_byte;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       check_ok;
    logic       end_of_run;
  } res_t;

  // Frame state carried between items
  typedef struct packed {
    logic [7:0] running_sum;
    logic [7:0] protected_id;
    logic       classic_selected;
    phase_t     phase;
  } frame_state_t;

  // Up to three result beats for one command, plus index of the final one
  typedef struct packed {
    res_t [2:0] beats;
    logic [1:0] last_idx;
  } res_bundle_t;

  // Protected id: P0 in bit 6, inverted P1 in bit 7
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // 8-bit add with end-around carry
  function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? (s[7:0] + 8'd1) : s[7:0];
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] value,
                                  input logic ok, input logic eor);
    res_t r;
    r.kind       = kind;
    r.value      = value;
    r.check_ok   = ok;
    r.end_of_run = eor;
    return r;
  endfunction

endpackage

>>> design/lmfe_chan.sv
// ----------------------------------------------------------------------------
// LIN master frame engine channel
// Valid/ready channel carrying one beat of type T.
// ----------------------------------------------------------------------------
interface lmfe_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/lin_master_frame_engine.sv
// Latency: first result beat is valid the cycle after the command beat is taken.
// Throughput: one result beat per cycle while res.ready is high; a command beat is taken
// every cycle while each gives one result and res.ready is high; a start command's three
// beats, or a last transmit or receive byte's two, drain before the next command is taken.
// Reset (rst, synchronous): frame phase idle, sum and protected id zero,
// result buffer empty.
// ----------------------------------------------------------------------------
// LIN master frame engine
// Frame header, byte pass-through, checksum generation and checking.
// ----------------------------------------------------------------------------
`include "lin_master_frame_engine_assert.svh"

module lin_master_frame_engine (
  input logic      clk,
  input logic      rst,
  lmfe_chan.sink   cmd,
  lmfe_chan.source res
);
  import lmfe_pkg::*;

  frame_state_t st;
  frame_state_t st_next;
  res_bundle_t  bundle;
  res_bundle_t  obuf;
  logic [1:0]   idx;
  logic         full;
  logic         cmd_take;
  logic         res_take;
  logic         drain_done;
  cmd_t         cmd_beat;

  assign cmd_beat = cmd_t'(cmd.data);

  lmfe_step u_step (
    .cmd     (cmd_beat),
    .st      (st),
    .st_next (st_next),
    .bundle  (bundle)
  );

  // Handshakes: accept a command when the buffer is empty or its final beat leaves
  assign res_take   = res.valid && res.ready;
  assign drain_done = res_take && (idx == obuf.last_idx);
  assign cmd.ready  = !full || drain_done;
  assign cmd_take   = cmd.valid && cmd.ready;

  assign res.valid = full;
  assign res.data  = obuf.beats[idx];

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.running_sum      <= 8'd0;
      st.protected_id     <= 8'd0;
      st.classic_selected <= 1'b0;
      st.phase            <= PH_IDLE;
    end else if (cmd_take) begin
      st <= st_next;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      obuf <= bundle;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (cmd_take) begin
      full <= 1'b1;
      idx  <= 2'd0;
    end else if (res_take) begin
      if (idx == obuf.last_idx) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Checks
  `LMFE_ASSERT_IMPL(a_idx_range, clk, rst, full, idx <= obuf.last_idx)
  `LMFE_ASSERT_IMPL(a_eor_final, clk, rst, full, res.data.end_of_run == (idx == obuf.last_idx))
  `LMFE_ASSERT_IMPL(a_classic_zero, clk, rst, st.classic_selected && (st.phase == PH_HEADER), st.running_sum == 8'd0)
  `LMFE_ASSERT_NEXT(a_start_break, clk, rst, cmd_take && (cmd_beat.op == OP_START), res.valid && (res.data.kind == KIND_BREAK))
  `LMFE_ASSERT(a_no_accept_mid, clk, rst, !(cmd.ready && full && (idx != obuf.last_idx)), "command taken mid-drain")

endmodule

>>> design/lmfe_step.sv
// ----------------------------------------------------------------------------
// LIN master frame engine step logic
// Next frame state and the result beats for one command.
// ----------------------------------------------------------------------------
module lmfe_step (
  input  lmfe_pkg::cmd_t         cmd,
  input  lmfe_pkg::frame_state_t st,
  output lmfe_pkg::frame_state_t st_next,
  output lmfe_pkg::res_bundle_t  bundle
);
  import lmfe_pkg::*;

  logic [7:0] pid;
  logic [7:0] sum_upd;
  logic [7:0] csum;
  logic       tx_ok;
  logic       rx_ok;

  assign pid     = make_pid(cmd.frame_id);
  assign sum_upd = sum_add(st.running_sum, cmd.data_byte);
  assign csum    = ~st.running_sum;
  assign tx_ok   = (st.phase == PH_HEADER) || (st.phase == PH_TX);
  assign rx_ok   = (st.phase == PH_HEADER) || (st.phase == PH_RX);

  always_comb begin
    st_next = st;
    bundle  = '0;
    case (cmd.op)
      OP_START: begin
        st_next.protected_id     = pid;
        st_next.classic_selected = cmd.classic_sum;
        st_next.running_sum      = cmd.classic_sum ? 8'd0 : pid;
        st_next.phase            = PH_HEADER;
        bundle.beats[0] = mk_res(KIND_BREAK, 8'd0, 1'b0, 1'b0);
        bundle.beats[1] = mk_res(KIND_TX, SYNC_BYTE, 1'b0, 1'b0);
        bundle.beats[2] = mk_res(KIND_TX, pid, 1'b0, 1'b1);
        bundle.last_idx = 2'd2;
      end
      OP_TX: begin
        if (tx_ok) begin
          st_next.running_sum = sum_upd;
          if (cmd.last) begin
            // data byte then the final checksum
            bundle.beats[0] = mk_res(KIND_TX, cmd.data_byte, 1'b0, 1'b0);
            bundle.beats[1] = mk_res(KIND_TX, ~sum_upd, 1'b0, 1'b1);
            bundle.last_idx = 2'd1;
            st_next.phase   = PH_IDLE;
          end else begin
            bundle.beats[0] = mk_res(KIND_TX, cmd.data_byte, 1'b0, 1'b1);
            st_next.phase   = PH_TX;
          end
        end else begin
          bundle.beats[0] = mk_res(KIND_SEQ_ERR, 8'd0, 1'b0, 1'b1);
          st_next.phase   = PH_IDLE;
        end
      end
      OP_RX: begin
        if (rx_ok) begin
          if (cmd.last) begin
            // received checksum: pass through, then compare
            bundle.beats[0] = mk_res(KIND_RX, cmd.data_byte, 1'b0, 1'b0);
            bundle.beats[1] = mk_res(KIND_CHECK, csum, csum == cmd.data_byte, 1'b1);
            bundle.last_idx = 2'd1;
            st_next.phase   = PH_IDLE;
          end else begin
            st_next.running_sum = sum_upd;
            bundle.beats[0] = mk_res(KIND_RX, cmd.data_byte, 1'b0, 1'b1);
            st_next.phase   = PH_RX;
          end
        end else begin
          bundle.beats[0] = mk_res(KIND_SEQ_ERR, 8'd0, 1'b0, 1'b1);
          st_next.phase   = PH_IDLE;
        end
      end
      default: begin
        bundle.beats[0] = mk_res(KIND_SEQ_ERR, 8'd0, 1'b0, 1'b1);
        st_next.phase   = PH_IDLE;
      end
    endcase
  end

endmodule
